@@ hdl/swrr_pkg.sv @@
// ---------------------------------------------------------------------------
// swrr_pkg
// Shared types, sizes and helpers for the smooth weighted round-robin table.
// ---------------------------------------------------------------------------
package swrr_pkg;

	localparam int MEMBER_SLOTS = 16;
	localparam int SLOT_W = (MEMBER_SLOTS > 1) ? $clog2(MEMBER_SLOTS) : 1;
	localparam int CNT_W  = $clog2(MEMBER_SLOTS + 1);

	localparam int ID_W   = 32;
	localparam int WT_W   = 8;
	localparam int PORT_W = 16;
	localparam int ADDR_W = 32;
	localparam int RUN_W  = 16;
	localparam int TOT_W  = $clog2(MEMBER_SLOTS * ((1 << WT_W) - 1) + 1);
	localparam int SUM_W  = ((RUN_W > TOT_W) ? RUN_W : TOT_W) + 2;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MEMBER_SLOTS - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MEMBER_SLOTS);

	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'((1 << (RUN_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(-(1 << (RUN_W - 1)));

	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_DEL  = 2'd1,
		CMD_PICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_WRBK,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   ident;
		logic [WT_W-1:0]   weight;
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] address;
	} member_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   ident;
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] address;
	} result_t;

	function automatic logic signed [RUN_W-1:0] sat_run(input logic signed [SUM_W-1:0] v);
		logic signed [RUN_W-1:0] r;
		if (v > SUM_HI) begin
			r = RUN_W'(SUM_HI);
		end else if (v < SUM_LO) begin
			r = RUN_W'(SUM_LO);
		end else begin
			r = RUN_W'(v);
		end
		return r;
	endfunction

endpackage

@@ hdl/smooth_weighted_round_robin_table_top.sv @@
// ---------------------------------------------------------------------------
// smooth_weighted_round_robin_table_top
// Member table with smooth weighted round-robin selection.
// ---------------------------------------------------------------------------
// One command word at a time: add, delete or pick, one result word each.
// Add and unused commands go from acceptance straight to the result state.
// Delete and pick sweep every slot of the member memories, one slot per
// cycle through a registered read; a pick does a read-modify-write of the
// running weight, then a write-back of the winner. A pick on an empty
// table skips the sweep, like an add. The output register lets the next
// command be taken while a result waits.
module smooth_weighted_round_robin_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] member_id,
	input  logic [7:0]  member_weight,
	input  logic [15:0] member_port,
	input  logic [31:0] member_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] chosen_id,
	output logic [15:0] chosen_port,
	output logic [31:0] chosen_address
);

	logic              res_valid;
	logic              res_ready;
	swrr_pkg::result_t res;

	swrr_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.member_id      (member_id),
		.member_weight  (member_weight),
		.member_port    (member_port),
		.member_address (member_address),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res)
	);

	swrr_outreg u_outreg (
		.clk            (clk),
		.arst_n         (arst_n),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.chosen_id      (chosen_id),
		.chosen_port    (chosen_port),
		.chosen_address (chosen_address)
	);

endmodule

@@ hdl/swrr_engine.sv @@
// ---------------------------------------------------------------------------
// swrr_engine
// Member and running-weight memories with the scan sequencer: add, delete
// search and the smooth weighted round-robin pick.
// ---------------------------------------------------------------------------
module swrr_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 command,
	input  logic [swrr_pkg::ID_W-1:0]   member_id,
	input  logic [swrr_pkg::WT_W-1:0]   member_weight,
	input  logic [swrr_pkg::PORT_W-1:0] member_port,
	input  logic [swrr_pkg::ADDR_W-1:0] member_address,
	output logic                       res_valid,
	input  logic                       res_ready,
	output swrr_pkg::result_t           res
);

	swrr_pkg::state_t state_q, state_d;

	// memories: member record and running weight, registered read
	swrr_pkg::member_t               member_mem_q [swrr_pkg::MEMBER_SLOTS];
	logic signed [swrr_pkg::RUN_W-1:0] run_mem_q    [swrr_pkg::MEMBER_SLOTS];

	logic [swrr_pkg::MEMBER_SLOTS-1:0] used_q;
	logic [swrr_pkg::CNT_W-1:0]        count_q;
	swrr_pkg::cmd_t                    cmd_q;
	logic [swrr_pkg::ID_W-1:0]         id_q;
	logic [swrr_pkg::SLOT_W-1:0]       addr_q;
	logic                              found_q;
	logic                              best_vld_q;
	logic [swrr_pkg::SLOT_W-1:0]       best_idx_q;
	logic signed [swrr_pkg::RUN_W-1:0] best_run_q;
	swrr_pkg::member_t                 best_mem_q;
	logic [swrr_pkg::TOT_W-1:0]        total_q;
	swrr_pkg::result_t                 res_q;

	logic                              vld_s1;
	logic [swrr_pkg::SLOT_W-1:0]       idx_s1;
	swrr_pkg::member_t                 member_s1;
	logic signed [swrr_pkg::RUN_W-1:0] run_s1;

	logic                              accept;
	logic                              full;
	logic [swrr_pkg::SLOT_W-1:0]       free_idx;
	swrr_pkg::cmd_t                    cmd_in;
	logic                              s1_used;
	logic signed [swrr_pkg::RUN_W-1:0] run_inc;
	logic signed [swrr_pkg::RUN_W-1:0] run_fin;
	logic                              better;
	logic                              del_hit;
	logic                              pick_upd;

	logic                              run_we;
	logic [swrr_pkg::SLOT_W-1:0]       run_wa;
	logic signed [swrr_pkg::RUN_W-1:0] run_wd;
	logic                              add_we;

	assign cmd_in = swrr_pkg::cmd_t'(command);
	assign accept = in_valid && (state_q == swrr_pkg::S_IDLE);
	assign full   = (count_q == swrr_pkg::FULL_CNT);
	assign add_we = accept && (cmd_in == swrr_pkg::CMD_ADD) && !full;

	always_comb begin
		free_idx = '0;
		for (int i = swrr_pkg::MEMBER_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = swrr_pkg::SLOT_W'(i);
			end
		end
	end

	assign s1_used = used_q[idx_s1];
	assign run_inc = swrr_pkg::sat_run($signed(swrr_pkg::SUM_W'(run_s1))
		+ $signed(swrr_pkg::SUM_W'(member_s1.weight)));
	assign run_fin = swrr_pkg::sat_run($signed(swrr_pkg::SUM_W'(best_run_q))
		- $signed(swrr_pkg::SUM_W'(total_q)));
	assign better   = !best_vld_q || (run_inc > best_run_q);
	assign pick_upd = vld_s1 && (cmd_q == swrr_pkg::CMD_PICK) && s1_used;
	assign del_hit  = vld_s1 && (cmd_q == swrr_pkg::CMD_DEL) && s1_used && !found_q
		&& (member_s1.ident == id_q);

	// running-weight write port: add clear, scan update, winner write-back.
	// scan writes slot i while slot i+1 is read, so no same-entry overlap.
	always_comb begin
		run_we = 1'b0;
		run_wa = free_idx;
		run_wd = '0;
		if (add_we) begin
			run_we = 1'b1;
		end else if (pick_upd) begin
			run_we = 1'b1;
			run_wa = idx_s1;
			run_wd = run_inc;
		end else if (state_q == swrr_pkg::S_WRBK && cmd_q == swrr_pkg::CMD_PICK) begin
			run_we = 1'b1;
			run_wa = best_idx_q;
			run_wd = run_fin;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			swrr_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (cmd_in)
						swrr_pkg::CMD_DEL:  state_d = swrr_pkg::S_SCAN;
						swrr_pkg::CMD_PICK: state_d = (count_q == '0) ? swrr_pkg::S_OUT
							: swrr_pkg::S_SCAN;
						default:            state_d = swrr_pkg::S_OUT;
					endcase
				end
			end
			swrr_pkg::S_SCAN: begin
				if (addr_q == swrr_pkg::LAST_SLOT) begin
					state_d = swrr_pkg::S_DRAIN;
				end
			end
			swrr_pkg::S_DRAIN: state_d = swrr_pkg::S_WRBK;
			swrr_pkg::S_WRBK:  state_d = swrr_pkg::S_OUT;
			swrr_pkg::S_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = swrr_pkg::S_IDLE;
				end
			end
			default: state_d = swrr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swrr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (add_we) begin
			member_mem_q[free_idx] <= '{ident: member_id, weight: member_weight,
				port: member_port, address: member_address};
		end
		if (run_we) begin
			run_mem_q[run_wa] <= run_wd;
		end
		member_s1 <= member_mem_q[addr_q];
		run_s1    <= run_mem_q[addr_q];
		idx_s1    <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			count_q    <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			best_vld_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == swrr_pkg::S_SCAN);
			if (accept) begin
				found_q    <= 1'b0;
				best_vld_q <= 1'b0;
			end
			if (add_we) begin
				used_q[free_idx] <= 1'b1;
				count_q          <= count_q + 1'b1;
			end
			if (del_hit) begin
				used_q[idx_s1] <= 1'b0;
				count_q        <= count_q - 1'b1;
				found_q        <= 1'b1;
			end
			if (pick_upd && better) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_in;
			id_q    <= member_id;
			addr_q  <= '0;
			total_q <= '0;
			if (cmd_in == swrr_pkg::CMD_ADD && full) begin
				res_q <= '{status: swrr_pkg::ST_FULL, default: '0};
			end else if (cmd_in == swrr_pkg::CMD_PICK && count_q == '0) begin
				res_q <= '{status: swrr_pkg::ST_EMPTY, default: '0};
			end else begin
				res_q <= '{status: swrr_pkg::ST_OK, default: '0};
			end
		end else if (state_q == swrr_pkg::S_SCAN) begin
			addr_q <= addr_q + 1'b1;
		end
		if (pick_upd) begin
			total_q <= total_q + swrr_pkg::TOT_W'(member_s1.weight);
			if (better) begin
				best_idx_q <= idx_s1;
				best_run_q <= run_inc;
				best_mem_q <= member_s1;
			end
		end
		if (state_q == swrr_pkg::S_WRBK) begin
			if (cmd_q == swrr_pkg::CMD_PICK) begin
				res_q <= '{status: swrr_pkg::ST_OK, ident: best_mem_q.ident,
					port: best_mem_q.port, address: best_mem_q.address};
			end else if (!found_q) begin
				res_q.status <= swrr_pkg::ST_NOTFOUND;
			end
		end
	end

	assign res = res_q;

endmodule

@@ hdl/swrr_outreg.sv @@
// ---------------------------------------------------------------------------
// swrr_outreg
// Output register: holds one result word so the engine can take the next
// command while a result waits downstream.
// ---------------------------------------------------------------------------
module swrr_outreg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_valid,
	output logic                        res_ready,
	input  swrr_pkg::result_t            res,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [swrr_pkg::ID_W-1:0]   chosen_id,
	output logic [swrr_pkg::PORT_W-1:0] chosen_port,
	output logic [swrr_pkg::ADDR_W-1:0] chosen_address
);

	logic              valid_q;
	swrr_pkg::result_t data_q;

	assign res_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			data_q <= res;
		end
	end

	assign out_valid      = valid_q;
	assign status         = data_q.status;
	assign chosen_id      = data_q.ident;
	assign chosen_port    = data_q.port;
	assign chosen_address = data_q.address;

endmodule

@@ hdl/swrr_checker.sv @@
// ---------------------------------------------------------------------------
// swrr_checker
// Port-level checks for the member table, bound to the top level.
// ---------------------------------------------------------------------------
module swrr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] chosen_id,
	input logic [15:0] chosen_port,
	input logic [31:0] chosen_address
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result word with no command outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two command words in flight");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("command taken while previous one still in work");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != swrr_pkg::ST_OK
		|-> chosen_id == '0 && chosen_port == '0 && chosen_address == '0)
		else $error("failed command carries a member");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(chosen_id)
		&& $stable(chosen_port) && $stable(chosen_address))
		else $error("result word changed while stalled");

endmodule

bind smooth_weighted_round_robin_table_top swrr_checker u_swrr_checker (.*);

@@ sim/smooth_weighted_round_robin_table_top_test.sv @@
// ---------------------------------------------------------------------------
// smooth_weighted_round_robin_table_top_test
// Self-checking bench for the smooth weighted round-robin member table.
// ---------------------------------------------------------------------------
// Every accepted command word is run through an in-bench model of the slot
// table and its running weights. Each result word is checked field by field
// against the oldest predicted result. Stimulus is a short directed sequence
// (empty table, unused command, zero weights, duplicate ids, full table)
// followed by random add/delete/pick traffic whose table fill level drifts
// between empty and full. Four pacing phases vary sender gaps and receiver
// stalls.
module smooth_weighted_round_robin_table_top_test;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = swrr_pkg::MEMBER_SLOTS + 24;
	localparam int WORDS_PER_PHASE = 475;
	localparam int ID_POOL = 12;

	class member_table_scoreboard;
		bit                          used[swrr_pkg::MEMBER_SLOTS];
		logic [swrr_pkg::ID_W-1:0]   ident[swrr_pkg::MEMBER_SLOTS];
		logic [swrr_pkg::WT_W-1:0]   weight[swrr_pkg::MEMBER_SLOTS];
		shortint                     running[swrr_pkg::MEMBER_SLOTS];
		logic [swrr_pkg::PORT_W-1:0] port[swrr_pkg::MEMBER_SLOTS];
		logic [swrr_pkg::ADDR_W-1:0] address[swrr_pkg::MEMBER_SLOTS];
		int                          used_count;
		swrr_pkg::result_t           pending_results[$];
		int                          accepted;
		int                          checked;
		int                          mismatches;
		int                          status_seen[4];

		function shortint clamp_run(int v);
			int hi;
			int lo;
			hi = (1 << (swrr_pkg::RUN_W - 1)) - 1;
			lo = -(1 << (swrr_pkg::RUN_W - 1));
			if (v > hi)
				return shortint'(hi);
			if (v < lo)
				return shortint'(lo);
			return shortint'(v);
		endfunction

		function swrr_pkg::result_t predict_result(swrr_pkg::cmd_t cmd,
				logic [swrr_pkg::ID_W-1:0] id, logic [swrr_pkg::WT_W-1:0] wt,
				logic [swrr_pkg::PORT_W-1:0] p, logic [swrr_pkg::ADDR_W-1:0] a);
			swrr_pkg::result_t r;
			int best;
			int total;
			r = '0;
			best = -1;
			total = 0;
			case (cmd)
			swrr_pkg::CMD_ADD: begin
				r.status = swrr_pkg::ST_FULL;
				for (int i = 0; i < swrr_pkg::MEMBER_SLOTS; i++) begin
					if (r.status == swrr_pkg::ST_FULL && !used[i]) begin
						used[i] = 1'b1;
						ident[i] = id;
						weight[i] = wt;
						running[i] = 0;
						port[i] = p;
						address[i] = a;
						used_count++;
						r.status = swrr_pkg::ST_OK;
					end
				end
			end
			swrr_pkg::CMD_DEL: begin
				r.status = swrr_pkg::ST_NOTFOUND;
				for (int i = 0; i < swrr_pkg::MEMBER_SLOTS; i++) begin
					if (r.status == swrr_pkg::ST_NOTFOUND && used[i] && ident[i] == id) begin
						used[i] = 1'b0;
						used_count--;
						r.status = swrr_pkg::ST_OK;
					end
				end
			end
			swrr_pkg::CMD_PICK: begin
				for (int i = 0; i < swrr_pkg::MEMBER_SLOTS; i++) begin
					if (used[i]) begin
						running[i] = clamp_run(int'(running[i]) + int'(weight[i]));
						total += int'(weight[i]);
						if (best < 0 || running[i] > running[best])
							best = i;
					end
				end
				if (best < 0) begin
					r.status = swrr_pkg::ST_EMPTY;
				end else begin
					running[best] = clamp_run(int'(running[best]) - total);
					r.status = swrr_pkg::ST_OK;
					r.ident = ident[best];
					r.port = port[best];
					r.address = address[best];
				end
			end
			default: r.status = swrr_pkg::ST_OK;
			endcase
			return r;
		endfunction

		function void note_command(swrr_pkg::cmd_t cmd, logic [swrr_pkg::ID_W-1:0] id,
				logic [swrr_pkg::WT_W-1:0] wt, logic [swrr_pkg::PORT_W-1:0] p,
				logic [swrr_pkg::ADDR_W-1:0] a);
			pending_results.push_back(predict_result(cmd, id, wt, p, a));
			accepted++;
		endfunction

		function void check_result(logic [1:0] st, logic [swrr_pkg::ID_W-1:0] id,
				logic [swrr_pkg::PORT_W-1:0] p, logic [swrr_pkg::ADDR_W-1:0] a);
			swrr_pkg::result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d id %h port %h addr %h",
						st, id, p, a);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			status_seen[want.status]++;
			if (st !== want.status || id !== want.ident || p !== want.port
					|| a !== want.address) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected status %0d id %h port %h addr %h, ",
						checked, want.status, want.ident, want.port, want.address,
						"got status %0d id %h port %h addr %h", st, id, p, a);
			end
		endfunction

		function logic [swrr_pkg::ID_W-1:0] used_id();
			int slots[$];
			for (int i = 0; i < swrr_pkg::MEMBER_SLOTS; i++)
				if (used[i])
					slots.push_back(i);
			return ident[slots[$urandom_range(slots.size() - 1)]];
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [31:0] member_id;
	logic [7:0]  member_weight;
	logic [15:0] member_port;
	logic [31:0] member_address;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] chosen_id;
	logic [15:0] chosen_port;
	logic [31:0] chosen_address;

	int send_idle_pct;
	int recv_stall_pct;
	int tx_free_left;
	int rx_free_left;
	int quiet_cycles;

	member_table_scoreboard book = new;

	smooth_weighted_round_robin_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.member_id(member_id),
		.member_weight(member_weight),
		.member_port(member_port),
		.member_address(member_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.chosen_id(chosen_id),
		.chosen_port(chosen_port),
		.chosen_address(chosen_address)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_word(swrr_pkg::cmd_t cmd, logic [31:0] id, logic [7:0] wt,
			logic [15:0] p, logic [31:0] a);
		@(negedge clk);
		if (tx_free_left > 0) begin
			tx_free_left--;
		end else if ($urandom_range(99) < 3) begin
			tx_free_left = $urandom_range(30, 10);
		end else begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		command = cmd;
		member_id = id;
		member_weight = wt;
		member_port = p;
		member_address = a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// receiver pacing, with occasional stall-free stretches
	always @(negedge clk) begin
		if (rx_free_left > 0) begin
			out_ready <= 1'b1;
			rx_free_left <= rx_free_left - 1;
		end else if ($urandom_range(99) < 2) begin
			out_ready <= 1'b1;
			rx_free_left <= $urandom_range(60, 20);
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				book.check_result(status, chosen_id, chosen_port, chosen_address);
			if (in_valid && in_ready)
				book.note_command(swrr_pkg::cmd_t'(command), member_id, member_weight,
					member_port, member_address);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("smooth_weighted_round_robin_table_top_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int send_idle_by_phase[4];
		int recv_stall_by_phase[4];
		logic [31:0] id_pool[ID_POOL];
		int sent;
		int target;
		int r;
		swrr_pkg::cmd_t c;
		logic [31:0] id;
		logic [7:0] wt;

		send_idle_by_phase = '{0, 83, 0, 13};
		recv_stall_by_phase = '{0, 0, 83, 13};
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < ID_POOL; i++)
			id_pool[i] = $urandom;

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		command = swrr_pkg::CMD_ADD;
		member_id = '0;
		member_weight = '0;
		member_port = '0;
		member_address = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		tx_free_left = 0;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, unused code, zero weights, duplicates, full table
		send_word(swrr_pkg::CMD_PICK, '1, '1, '1, '1);
		send_word(swrr_pkg::CMD_DEL, '0, '0, '0, '0);
		send_word(swrr_pkg::CMD_NONE, '1, '1, '1, '1);
		send_word(swrr_pkg::CMD_ADD, '0, '0, '0, '0);
		send_word(swrr_pkg::CMD_PICK, '0, '0, '0, '0);
		send_word(swrr_pkg::CMD_ADD, '1, '1, '1, '1);
		send_word(swrr_pkg::CMD_ADD, '1, 8'd1, 16'h1234, 32'h0a000001);
		for (int k = 0; k < swrr_pkg::MEMBER_SLOTS - 3; k++)
			send_word(swrr_pkg::CMD_ADD, 32'h100 + k, 8'(k * 19 + 7), 16'(k * 4999),
				$urandom);
		send_word(swrr_pkg::CMD_ADD, 32'hdead_beef, 8'd9, 16'h5555, 32'haaaa_aaaa);
		send_word(swrr_pkg::CMD_PICK, '0, '0, '0, '0);
		send_word(swrr_pkg::CMD_PICK, '1, '1, '1, '1);
		send_word(swrr_pkg::CMD_DEL, '1, '0, '0, '0);
		send_word(swrr_pkg::CMD_PICK, '0, '0, '0, '0);
		send_word(swrr_pkg::CMD_DEL, '0, '1, '1, '1);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_idle_by_phase[ph];
			recv_stall_pct = recv_stall_by_phase[ph];
			sent = 0;
			target = swrr_pkg::MEMBER_SLOTS;
			while (sent < WORDS_PER_PHASE) begin
				if (sent % 64 == 0)
					target = $urandom_range(swrr_pkg::MEMBER_SLOTS, 0);
				r = $urandom_range(99);
				if (r < 4)
					c = swrr_pkg::CMD_NONE;
				else if (r < 50)
					c = swrr_pkg::CMD_PICK;
				else if ((book.used_count < target) == ($urandom_range(9) < 8))
					c = swrr_pkg::CMD_ADD;
				else
					c = swrr_pkg::CMD_DEL;
				id = id_pool[$urandom_range(ID_POOL - 1)];
				if (c == swrr_pkg::CMD_DEL) begin
					r = $urandom_range(9);
					if (r < 7 && book.used_count > 0)
						id = book.used_id();
					else if (r == 9)
						id = $urandom;
				end else if (c != swrr_pkg::CMD_ADD || $urandom_range(19) == 0) begin
					id = $urandom;
				end
				r = $urandom_range(9);
				if (r == 0)
					wt = '0;
				else if (r == 1)
					wt = '1;
				else if (r < 6)
					wt = 8'($urandom_range(8, 1));
				else
					wt = 8'($urandom_range(255));
				send_word(c, id, wt, 16'($urandom), $urandom);
				sent++;
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (book.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d command words accepted, %0d result words checked, %0d mismatches",
			book.accepted, book.checked, book.mismatches);
		$display("status mix: ok %0d, table full %0d, unknown id %0d, empty pick %0d",
			book.status_seen[swrr_pkg::ST_OK], book.status_seen[swrr_pkg::ST_FULL],
			book.status_seen[swrr_pkg::ST_NOTFOUND], book.status_seen[swrr_pkg::ST_EMPTY]);
		if (book.mismatches == 0 && book.pending_results.size() == 0)
			$display("smooth_weighted_round_robin_table_top_test OK");
		else
			$display("smooth_weighted_round_robin_table_top_test NOT OK");
		$finish;
	end

endmodule
